// ===== rtl/core/seq_pkg.sv =====
package seq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int TAG_BITS    = 16;
   localparam int DATE_W      = 27;
   localparam int TIME_W      = 18;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 7;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W  = ((CMD_W + DATE_W + TIME_W + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W  =
      ((STATUS_W + DATE_W + TIME_W + TAG_BITS + OCC_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_PEEK   = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [DATE_W-1:0]   date;
      logic [TIME_W-1:0]   time_key;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/seq_cell.sv =====
module seq_cell (
   input  logic                   clock,
   input  seq_pkg::cell_ctrl_type ctrl,
   input  seq_pkg::entry_type     new_entry,
   input  logic                   occupied,
   input  logic                   prev_lt,
   input  seq_pkg::entry_type     left_entry,
   input  seq_pkg::entry_type     right_entry,
   output seq_pkg::entry_type     entry,
   output logic                   lt
);

   seq_pkg::entry_type entry_ff;
   seq_pkg::entry_type entry_in;

   assign lt = occupied &&
      ({entry_ff.date, entry_ff.time_key} < {new_entry.date, new_entry.time_key});

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (!lt) begin
            entry_in = prev_lt ? new_entry : left_entry;
         end
      end else if (ctrl.rem) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/sorted_event_queue_top.sv =====
// Each request word is registered, then the EXEC state runs the command as one
//   compare-and-shift step across the whole cell chain and holds the response in
//   an output register. Requests are taken in IDLE while that register is free.
// Reset: synchronous, active high; clears the entry count and the handshake
//   state. Slot contents are not cleared; only slots below the count are read.
module sorted_event_queue_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // command, date_key, time_key, event_tag, zero pad
   input  logic [seq_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status, front_date, front_time, front_tag, occupancy, zero pad
   output logic [seq_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int DEPTH = seq_pkg::QUEUE_DEPTH;
   localparam int REQ_USED = seq_pkg::CMD_W + seq_pkg::DATE_W + seq_pkg::TIME_W
                             + seq_pkg::TAG_BITS;
   localparam int RSP_USED = seq_pkg::STATUS_W + seq_pkg::DATE_W + seq_pkg::TIME_W
                             + seq_pkg::TAG_BITS + seq_pkg::OCC_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                   state_ff, state_in;
   logic [seq_pkg::CMD_W-1:0]   cmd_ff;
   seq_pkg::entry_type          key_ff;
   logic [seq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_USED-1:0]         rsp_ff, rsp_in;

   seq_pkg::cell_ctrl_type      ctrl;
   seq_pkg::entry_type          cell_entry [DEPTH];
   logic [DEPTH-1:0]            cell_lt;
   logic                        full;
   logic                        empty;
   logic                        req_fire;
   seq_pkg::status_type         status;
   seq_pkg::entry_type          front;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign full  = (count_ff == seq_pkg::CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      ctrl.ins = 1'b0;
      ctrl.rem = 1'b0;
      status   = seq_pkg::ST_OK;
      front    = '0;
      count_in = count_ff;
      if (state_ff == S_EXEC) begin
         case (cmd_ff) inside
            seq_pkg::CMD_INSERT: begin
               if (full) begin
                  status = seq_pkg::ST_FULL;
               end else begin
                  ctrl.ins = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            seq_pkg::CMD_PEEK, seq_pkg::CMD_REMOVE: begin
               if (empty) begin
                  status = seq_pkg::ST_EMPTY;
               end else begin
                  front = cell_entry[0];
                  if (cmd_ff == seq_pkg::CMD_REMOVE) begin
                     ctrl.rem = 1'b1;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         seq_pkg::entry_type left_e;
         seq_pkg::entry_type right_e;
         logic               p_lt;
         if (i == 0) begin : g_first
            assign left_e = key_ff;
            assign p_lt   = 1'b1;
         end else begin : g_mid
            assign left_e = cell_entry[i-1];
            assign p_lt   = cell_lt[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_e = cell_entry[i];
         end else begin : g_inner
            assign right_e = cell_entry[i+1];
         end
         seq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .new_entry   (key_ff),
            .occupied    (seq_pkg::CNT_W'(i) < count_ff),
            .prev_lt     (p_lt),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .lt          (cell_lt[i])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = {seq_pkg::OCC_W'(count_in), front.tag, front.time_key,
                            front.date, status};
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_fire) begin
         cmd_ff       <= req_tdata[seq_pkg::CMD_W-1:0];
         key_ff       <= {req_tdata[seq_pkg::CMD_W +: seq_pkg::DATE_W],
                          req_tdata[seq_pkg::CMD_W + seq_pkg::DATE_W +: seq_pkg::TIME_W],
                          req_tdata[REQ_USED-1 -: seq_pkg::TAG_BITS]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = seq_pkg::RSP_DATA_W'(rsp_ff);

endmodule
